// File: src/bcfe_pkg.sv
// ---------------------------------------------------------------------------
// bcfe_pkg: shared types and BCD helpers for the calendar field editor
// Operation codes, field codes, field limits, BCD step/repair functions and
// the command bundle between controller and datapath.
// ---------------------------------------------------------------------------
package bcfe_pkg;

	localparam int FLD_W     = 3;
	localparam int FLD_COUNT = 6;

	localparam logic [FLD_W-1:0] FLD_YEAR    = 3'd0;
	localparam logic [FLD_W-1:0] FLD_MONTH   = 3'd1;
	localparam logic [FLD_W-1:0] FLD_DAY     = 3'd2;
	localparam logic [FLD_W-1:0] FLD_HOURS   = 3'd3;
	localparam logic [FLD_W-1:0] FLD_MINUTES = 3'd4;
	localparam logic [FLD_W-1:0] FLD_SECONDS = 3'd5;

	// codes 6 and 7 act as a read
	typedef enum logic [2:0] {
		OP_READ        = 3'd0,
		OP_WRITE       = 3'd1,
		OP_INC         = 3'd2,
		OP_DEC         = 3'd3,
		OP_LOAD        = 3'd4,
		OP_CORRECT_DAY = 3'd5
	} op_t;

	localparam logic [7:0] BCD_MONTH_DEFAULT = 8'h01;
	localparam logic [7:0] BCD_DAY_DEFAULT   = 8'h01;

	typedef struct packed {
		logic load;   // capture the input transfer
		logic exec;   // apply the operation, load the result register
	} bcfe_cmd_t;

	function automatic logic [7:0] lower_limit(input logic [FLD_W-1:0] f);
		logic [7:0] r;
		r = ((f == FLD_MONTH) || (f == FLD_DAY)) ? 8'h01 : 8'h00;
		return r;
	endfunction

	function automatic logic [7:0] upper_limit(input logic [FLD_W-1:0] f);
		logic [7:0] r;
		unique case (f)
			FLD_YEAR:    r = 8'h99;
			FLD_MONTH:   r = 8'h12;
			FLD_DAY:     r = 8'h31;
			FLD_HOURS:   r = 8'h23;
			default:     r = 8'h59;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] bcd_to_dec(input logic [7:0] b);
		logic [7:0] t;
		logic [7:0] o;
		t = {4'b0, b[7:4]};
		o = {4'b0, b[3:0]};
		return (t << 3) + (t << 1) + o;
	endfunction

	function automatic logic [7:0] month_len(input logic [7:0] month, input logic [7:0] year);
		logic [7:0] yd;
		logic [7:0] r;
		yd = bcd_to_dec(year);
		if ((month == 8'h04) || (month == 8'h06) || (month == 8'h09) || (month == 8'h11))
			r = 8'h30;
		else if (month == 8'h02)
			r = (yd[1:0] != 2'b00) ? 8'h28 : 8'h29;
		else
			r = 8'h31;
		return r;
	endfunction

	function automatic logic [7:0] step_up(input logic [7:0] v, input logic [7:0] lo,
	                                       input logic [7:0] hi);
		logic [7:0] n;
		logic [7:0] c;
		n = v + 8'h01;
		c = n + 8'h10;
		if (v == hi)
			return lo;
		if (n[3:0] > 4'h9)
			return {c[7:4], 4'h0};
		return n;
	endfunction

	function automatic logic [7:0] step_down(input logic [7:0] v, input logic [7:0] lo,
	                                         input logic [7:0] hi);
		logic [7:0] n;
		n = v - 8'h01;
		if (v == lo)
			return hi;
		if (n[3:0] > 4'h9)
			return {n[7:4], 4'h9};
		return n;
	endfunction

	function automatic logic [7:0] repair(input logic [7:0] v, input logic [7:0] lo,
	                                      input logic [7:0] hi);
		logic [7:0] r;
		if ((v[3:0] > 4'h9) || (v[7:4] > 4'h9))
			r = lo;
		else if (v < lo)
			r = lo;
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

// File: src/bcd_calendar_field_editor_core.sv
// ---------------------------------------------------------------------------
// bcd_calendar_field_editor_core: BCD calendar field editor, top level
// Six BCD calendar bytes (year, month, day, hours, minutes, seconds) edited
// by read / write / increment / decrement / checked load / correct day.
// Usage: one item in on s_* (one transfer), one result out on m_*.
// Sequence: the item is captured at its transfer edge and executed once
// the output register is free; the execute step sets m_tvalid.
// Flow: the controller's two-state sequence (capture, execute) takes one
// item at a time; no new item is taken before the last is executed. A new
// item is taken while the last result still waits in the output register.
// Stall: if m_tready is low the execute step waits until the output
// register is free; s_tready stays low meanwhile.
// Reset: arst_n clears the controller, drops m_tvalid, and loads the
// calendar with year 00, month 01, day 01, time 00:00:00.
// ---------------------------------------------------------------------------
module bcd_calendar_field_editor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // operation[2:0], field[5:3], write_value[13:6], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // value_bcd[7:0], value_decimal[15:8], corrected[16], zero
);

	bcfe_pkg::bcfe_cmd_t cmd;
	logic [7:0]          value_bcd;
	logic [7:0]          value_decimal;
	logic                corrected;

	// sequencing: capture, then execute when the result register is free
	bcfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// calendar store, BCD edit logic and result register
	bcfe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (s_tdata[2:0]),
		.field         (s_tdata[5:3]),
		.write_value   (s_tdata[13:6]),
		.value_bcd     (value_bcd),
		.value_decimal (value_decimal),
		.corrected     (corrected)
	);

	assign m_tdata = {7'b0, corrected, value_decimal, value_bcd};

	// one item at a time: no second capture right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	// execute never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before transfer");

	// every execute step presents a result
	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("executed item produced no result");

	// a taken result disappears unless a new one was executed
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !cmd.exec) |=> !m_tvalid)
		else $error("result repeated after transfer");

endmodule

// File: src/bcfe_ctrl.sv
// ---------------------------------------------------------------------------
// bcfe_ctrl: transfer controller for the calendar field editor
// Takes one item at a time, fires the execute step once the result register
// is free, and owns the output valid flag.
// ---------------------------------------------------------------------------
module bcfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bcfe_pkg::bcfe_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   room;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign room      = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.exec = (state_q == ST_EXEC) && room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready)
						out_valid_q <= 1'b0;
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (room) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/bcfe_datapath.sv
// ---------------------------------------------------------------------------
// bcfe_datapath: calendar registers and BCD edit logic
// Holds the captured item, the six calendar bytes and the result register.
// ---------------------------------------------------------------------------
module bcfe_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bcfe_pkg::bcfe_cmd_t cmd,
	input  logic [2:0]          operation,
	input  logic [2:0]          field,
	input  logic [7:0]          write_value,
	output logic [7:0]          value_bcd,
	output logic [7:0]          value_decimal,
	output logic                corrected
);

	logic [2:0] op_q;
	logic [2:0] fld_q;
	logic [7:0] wv_q;
	logic [7:0] cal_q [bcfe_pkg::FLD_COUNT];
	logic [7:0] bcd_q;
	logic [7:0] dec_q;
	logic       corr_q;

	logic [2:0] sel_fld;
	logic       sel_ok;
	logic [7:0] cur_val;
	logic [7:0] mlen;
	logic [7:0] lo;
	logic [7:0] hi;
	logic [7:0] fixed;
	logic [7:0] new_val;
	logic       new_corr;
	logic [7:0] res_bcd;

	assign sel_fld = (op_q == bcfe_pkg::OP_CORRECT_DAY) ? bcfe_pkg::FLD_DAY : fld_q;
	assign sel_ok  = (sel_fld < 3'(bcfe_pkg::FLD_COUNT));
	assign cur_val = sel_ok ? cal_q[sel_fld] : 8'h00;
	assign mlen    = bcfe_pkg::month_len(cal_q[bcfe_pkg::FLD_MONTH], cal_q[bcfe_pkg::FLD_YEAR]);
	assign lo      = bcfe_pkg::lower_limit(sel_fld);
	assign hi      = (sel_fld == bcfe_pkg::FLD_DAY) ? mlen : bcfe_pkg::upper_limit(sel_fld);
	assign fixed   = bcfe_pkg::repair(wv_q, lo, bcfe_pkg::upper_limit(sel_fld));

	always_comb begin
		new_val  = cur_val;
		new_corr = 1'b0;
		unique case (op_q)
			bcfe_pkg::OP_WRITE: new_val = wv_q;
			bcfe_pkg::OP_INC:   new_val = bcfe_pkg::step_up(cur_val, lo, hi);
			bcfe_pkg::OP_DEC:   new_val = bcfe_pkg::step_down(cur_val, lo, hi);
			bcfe_pkg::OP_LOAD: begin
				new_val  = ((sel_fld == bcfe_pkg::FLD_DAY) && (fixed > hi)) ? hi : fixed;
				new_corr = (new_val != wv_q);
			end
			bcfe_pkg::OP_CORRECT_DAY: begin
				if (cur_val > mlen) begin
					new_val  = mlen;
					new_corr = 1'b1;
				end
			end
			default: new_val = cur_val;
		endcase
	end

	assign res_bcd = sel_ok ? new_val : 8'h00;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			fld_q <= field;
			wv_q  <= write_value;
		end
		if (cmd.exec) begin
			bcd_q  <= res_bcd;
			dec_q  <= bcfe_pkg::bcd_to_dec(res_bcd);
			corr_q <= sel_ok && new_corr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q[bcfe_pkg::FLD_YEAR]    <= 8'h00;
			cal_q[bcfe_pkg::FLD_MONTH]   <= bcfe_pkg::BCD_MONTH_DEFAULT;
			cal_q[bcfe_pkg::FLD_DAY]     <= bcfe_pkg::BCD_DAY_DEFAULT;
			cal_q[bcfe_pkg::FLD_HOURS]   <= 8'h00;
			cal_q[bcfe_pkg::FLD_MINUTES] <= 8'h00;
			cal_q[bcfe_pkg::FLD_SECONDS] <= 8'h00;
		end else if (cmd.exec && sel_ok) begin
			cal_q[sel_fld] <= new_val;
		end
	end

	assign value_bcd     = bcd_q;
	assign value_decimal = dec_q;
	assign corrected     = corr_q;

endmodule

// File: tb/calendar_edit_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// calendar_edit_checker: readback predictor and scoreboard for the editor
// Watches both stream channels. Each input transfer is applied to a private
// copy of the six BCD calendar bytes and the readback it should produce is
// queued. Each output transfer is compared field by field with the oldest
// queued readback. Reports the first ten mismatches, counts the rest.
// ---------------------------------------------------------------------------
module calendar_edit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // operation[2:0], field[5:3], write_value[13:6], zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // value_bcd[7:0], value_decimal[15:8], corrected[16], zero
	output int          outstanding,
	output int          mismatches
);

	typedef struct packed {
		logic       corrected;
		logic [7:0] dec;
		logic [7:0] bcd;
	} readback_t;

	logic [7:0] cal [bcfe_pkg::FLD_COUNT];
	readback_t  field_readbacks [$];

	function automatic logic [7:0] dec_of(input logic [7:0] b);
		return 8'(b[7:4] * 10 + b[3:0]);
	endfunction

	function automatic logic [7:0] field_floor(input logic [2:0] f);
		return (f == bcfe_pkg::FLD_MONTH || f == bcfe_pkg::FLD_DAY) ? 8'h01 : 8'h00;
	endfunction

	function automatic logic [7:0] field_ceiling(input logic [2:0] f);
		logic [7:0] c;
		case (f)
			bcfe_pkg::FLD_YEAR:  c = 8'h99;
			bcfe_pkg::FLD_MONTH: c = 8'h12;
			bcfe_pkg::FLD_DAY:   c = 8'h31;
			bcfe_pkg::FLD_HOURS: c = 8'h23;
			default:             c = 8'h59;
		endcase
		return c;
	endfunction

	// last day of the stored month; leap test on the decimal year
	function automatic logic [7:0] days_in_month();
		logic [7:0] m;
		logic [7:0] y;
		m = cal[bcfe_pkg::FLD_MONTH];
		y = dec_of(cal[bcfe_pkg::FLD_YEAR]);
		if (m == 8'h04 || m == 8'h06 || m == 8'h09 || m == 8'h11)
			return 8'h30;
		if (m == 8'h02)
			return (y[1:0] != 2'b00) ? 8'h28 : 8'h29;
		return 8'h31;
	endfunction

	function automatic logic [7:0] bcd_inc(input logic [7:0] v, input logic [7:0] lo,
	                                       input logic [7:0] hi);
		logic [7:0] n;
		if (v == hi)
			return lo;
		n = v + 8'h01;
		if (n[3:0] > 4'h9)
			n = (n + 8'h10) & 8'hF0;
		return n;
	endfunction

	function automatic logic [7:0] bcd_dec(input logic [7:0] v, input logic [7:0] lo,
	                                       input logic [7:0] hi);
		logic [7:0] n;
		if (v == lo)
			return hi;
		n = v - 8'h01;
		if (n[3:0] > 4'h9)
			n = {n[7:4], 4'h9};
		return n;
	endfunction

	// bad digit -> floor, else clamp into [lo, hi]
	function automatic logic [7:0] bcd_fix(input logic [7:0] v, input logic [7:0] lo,
	                                       input logic [7:0] hi);
		if (v[3:0] > 4'h9 || v[7:4] > 4'h9)
			return lo;
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// applies one edit to the calendar copy, returns the readback it causes
	function automatic readback_t edit_field(input logic [2:0] op, input logic [2:0] fld,
	                                         input logic [7:0] wv);
		readback_t  r;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] v;
		logic [2:0] f;
		r = '0;
		f = fld;
		if (op == bcfe_pkg::OP_CORRECT_DAY) begin
			hi = days_in_month();
			if (cal[bcfe_pkg::FLD_DAY] > hi) begin
				cal[bcfe_pkg::FLD_DAY] = hi;
				r.corrected = 1'b1;
			end
			f = bcfe_pkg::FLD_DAY;
		end else if (fld >= bcfe_pkg::FLD_COUNT) begin
			return r;
		end else begin
			lo = field_floor(fld);
			hi = (fld == bcfe_pkg::FLD_DAY) ? days_in_month() : field_ceiling(fld);
			case (op)
				bcfe_pkg::OP_WRITE: cal[fld] = wv;
				bcfe_pkg::OP_INC:   cal[fld] = bcd_inc(cal[fld], lo, hi);
				bcfe_pkg::OP_DEC:   cal[fld] = bcd_dec(cal[fld], lo, hi);
				bcfe_pkg::OP_LOAD: begin
					v = bcd_fix(wv, lo, field_ceiling(fld));
					if (fld == bcfe_pkg::FLD_DAY && v > hi)
						v = hi;
					cal[fld] = v;
					r.corrected = (v != wv);
				end
				default: ;
			endcase
		end
		r.bcd = cal[f];
		r.dec = dec_of(cal[f]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		readback_t want;
		readback_t got;
		if (!arst_n) begin
			for (int i = 0; i < bcfe_pkg::FLD_COUNT; i++)
				cal[i] = 8'h00;
			cal[bcfe_pkg::FLD_MONTH] = 8'h01;
			cal[bcfe_pkg::FLD_DAY]   = 8'h01;
			field_readbacks.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// results leave before new items enter: a result never belongs to
			// an item taken on the same edge
			if (m_tvalid && m_tready) begin
				got.bcd       = m_tdata[7:0];
				got.dec       = m_tdata[15:8];
				got.corrected = m_tdata[16];
				if (field_readbacks.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result %h with no item pending", $realtime, m_tdata);
					mismatches++;
				end else begin
					want = field_readbacks.pop_front();
					if (got != want) begin
						if (mismatches < 10)
							$display("%0t: bcd exp %h got %h, dec exp %0d got %0d, corr exp %b got %b",
							         $realtime, want.bcd, got.bcd, want.dec, got.dec,
							         want.corrected, got.corrected);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				field_readbacks.push_back(edit_field(s_tdata[2:0], s_tdata[5:3], s_tdata[13:6]));
			outstanding <= field_readbacks.size();
		end
	end

endmodule

// File: tb/tb_bcd_calendar_field_editor_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bcd_calendar_field_editor_core: stream testbench for the field editor
// Drives edit items with random gaps and random output back-pressure: a
// directed pass over limits, wraps, repairs and month lengths, then random
// single edits and well-formed date sequences. The checker predicts and
// compares every readback; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_bcd_calendar_field_editor_core;

	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_TARGET = 1100;
	localparam int HOLD_AT     = 400;   // transfers before the long receiver hold
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_AT    = 700;   // transfers before the mid-run drain

	// codes the block treats as read / as no field
	localparam logic [2:0] OP_SPARE_LO  = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam logic [2:0] FLD_SPARE_LO = 3'd6;
	localparam logic [2:0] FLD_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        hold_rx;
	int          outstanding;
	int          mismatches;
	int          sent;
	int          cycle_count;

	bcd_calendar_field_editor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	calendar_edit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// cycle_count starts at zero as an int
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] to_bcd(input int n);
		return 8'(((n / 10) << 4) | (n % 10));
	endfunction

	function automatic logic [2:0] rand_op();
		if ($urandom_range(0, 99) < 5)
			return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		return 3'($urandom_range(0, 5));
	endfunction

	function automatic logic [2:0] rand_fld();
		if ($urandom_range(0, 99) < 5)
			return $urandom_range(0, 1) ? FLD_SPARE_HI : FLD_SPARE_LO;
		return 3'($urandom_range(0, 5));
	endfunction

	// mostly legal BCD for the field, some any BCD, some any byte
	function automatic logic [7:0] rand_value(input logic [2:0] fld);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case (fld)
				bcfe_pkg::FLD_MONTH: return to_bcd($urandom_range(1, 12));
				bcfe_pkg::FLD_DAY:   return to_bcd($urandom_range(1, 31));
				bcfe_pkg::FLD_HOURS: return to_bcd($urandom_range(0, 23));
				bcfe_pkg::FLD_YEAR:  return to_bcd($urandom_range(0, 99));
				default:             return to_bcd($urandom_range(0, 59));
			endcase
		end
		if (r < 80)
			return to_bcd($urandom_range(0, 99));
		return 8'($urandom_range(0, 255));
	endfunction

	// one input transfer; gap drawn per item, every third hundred without gaps
	task automatic send_edit(input logic [2:0] op, input logic [2:0] fld, input logic [7:0] wv);
		int gap;
		gap = ((sent / 100) % 3 == 2) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, wv, fld, op};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// set a date near month end, step it, then pull the day back in range
	task automatic date_sequence();
		int n;
		if ($urandom_range(0, 1))
			send_edit($urandom_range(0, 1) ? bcfe_pkg::OP_WRITE : bcfe_pkg::OP_LOAD,
			          bcfe_pkg::FLD_YEAR, to_bcd($urandom_range(0, 99)));
		send_edit($urandom_range(0, 3) ? bcfe_pkg::OP_LOAD : bcfe_pkg::OP_WRITE,
		          bcfe_pkg::FLD_MONTH, to_bcd($urandom_range(1, 12)));
		send_edit($urandom_range(0, 1) ? bcfe_pkg::OP_WRITE : bcfe_pkg::OP_LOAD,
		          bcfe_pkg::FLD_DAY, to_bcd($urandom_range(25, 31)));
		n = $urandom_range(0, 4);
		repeat (n)
			send_edit($urandom_range(0, 1) ? bcfe_pkg::OP_INC : bcfe_pkg::OP_DEC,
			          $urandom_range(0, 2) ? bcfe_pkg::FLD_DAY : bcfe_pkg::FLD_MONTH,
			          8'($urandom_range(0, 255)));
		send_edit(bcfe_pkg::OP_CORRECT_DAY, 3'($urandom_range(0, 7)),
		          8'($urandom_range(0, 255)));
		send_edit(bcfe_pkg::OP_READ, bcfe_pkg::FLD_DAY, 8'($urandom_range(0, 255)));
	endtask

	// receiver: per-result stall, longer hold while hold_rx is set
	initial begin
		int gap;
		int taken;
		taken = 0;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = ((taken / 100) % 3 == 1) ? 0 : $urandom_range(0, 19);
			if (gap > 0 || hold_rx) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// long back-pressure while the sender keeps offering items
	initial begin
		hold_rx <= 1'b0;
		wait (sent >= HOLD_AT);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		int  pick;
		bit  drained;
		sent        = 0;
		drained     = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, wraps at both limits, stepping out-of-range
		// bytes, repairs and clamps, leap and short months, ignored codes
		send_edit(bcfe_pkg::OP_READ,  bcfe_pkg::FLD_YEAR,    8'hFF);
		send_edit(bcfe_pkg::OP_READ,  bcfe_pkg::FLD_DAY,     8'h00);
		send_edit(bcfe_pkg::OP_DEC,   bcfe_pkg::FLD_MONTH,   8'h00);   // 01 -> 12
		send_edit(bcfe_pkg::OP_INC,   bcfe_pkg::FLD_MONTH,   8'h00);   // 12 -> 01
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_YEAR,    8'h99);
		send_edit(bcfe_pkg::OP_INC,   bcfe_pkg::FLD_YEAR,    8'h00);   // 99 -> 00
		send_edit(bcfe_pkg::OP_DEC,   bcfe_pkg::FLD_YEAR,    8'h00);   // 00 -> 99
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_MINUTES, 8'h5A);   // bad ones digit kept raw
		send_edit(bcfe_pkg::OP_INC,   bcfe_pkg::FLD_MINUTES, 8'h00);
		send_edit(bcfe_pkg::OP_DEC,   bcfe_pkg::FLD_MINUTES, 8'h00);
		send_edit(bcfe_pkg::OP_LOAD,  bcfe_pkg::FLD_HOURS,   8'hFF);   // bad digits -> floor
		send_edit(bcfe_pkg::OP_LOAD,  bcfe_pkg::FLD_HOURS,   8'h24);   // clamp to 23
		send_edit(bcfe_pkg::OP_LOAD,  bcfe_pkg::FLD_SECONDS, 8'h59);   // in range, no correction
		send_edit(bcfe_pkg::OP_LOAD,  bcfe_pkg::FLD_MONTH,   8'h00);   // below floor
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_MONTH,   8'h02);
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_YEAR,    8'h24);   // leap year
		send_edit(bcfe_pkg::OP_LOAD,  bcfe_pkg::FLD_DAY,     8'h31);   // clamps to 29
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_YEAR,    8'h23);
		send_edit(bcfe_pkg::OP_CORRECT_DAY, bcfe_pkg::FLD_YEAR, 8'h00); // 29 -> 28
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_MONTH,   8'h04);
		send_edit(bcfe_pkg::OP_WRITE, bcfe_pkg::FLD_DAY,     8'h31);
		send_edit(bcfe_pkg::OP_CORRECT_DAY, FLD_SPARE_HI, 8'hAA); // field ignored, 31 -> 30
		send_edit(bcfe_pkg::OP_INC,   bcfe_pkg::FLD_DAY,     8'h00);   // 30 -> 01 in April
		send_edit(bcfe_pkg::OP_READ,  FLD_SPARE_HI, 8'h55);  // no field: zeros
		send_edit(bcfe_pkg::OP_WRITE, FLD_SPARE_LO, 8'h42);  // no field: no change
		send_edit(OP_SPARE_LO, bcfe_pkg::FLD_DAY,  8'h33);   // acts as read
		send_edit(OP_SPARE_HI, bcfe_pkg::FLD_MONTH, 8'hCC);
		drain_results();

		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				date_sequence();
			end else if (pick < 90) begin
				logic [2:0] f;
				f = rand_fld();
				send_edit(rand_op(), f, rand_value(f));
			end else begin
				send_edit(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				          8'($urandom_range(0, 255)));
			end
			if (sent >= DRAIN_AT && !drained) begin
				drain_results();
				drained = 1'b1;
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
src/bcfe_pkg.sv
src/bcfe_ctrl.sv
src/bcfe_datapath.sv
src/bcd_calendar_field_editor_core.sv
tb/calendar_edit_checker.sv
tb/tb_bcd_calendar_field_editor_core.sv
